[design/ffa_pkg.sv]
// shared types and constants of the first-fit block allocator
`default_nettype none

package ffa_pkg;

  // fixed field widths of the transaction payload
  localparam int OPCODE_W = 2;
  localparam int BYTES_W  = 16;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;

  // granule geometry
  localparam int GRAN_LOG2 = 4;

  // header entry: free bit, recorded size, span
  localparam int FIELD_W = 12;
  localparam int ENTRY_W = 2 * FIELD_W + 1;
  localparam int FREE_B  = 2 * FIELD_W;

  // granule pointers and sizes: end of heap, walk pointer, need
  localparam int PTR_W  = FIELD_W + 1;
  localparam int NEED_W = BYTES_W - GRAN_LOG2 + 1;

  // default heap depth in granules
  localparam int HEAP_GRANULES_DEF = 4096;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_NULL = 2'd1,
    STATUS_OOM  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_RS_RD,
    ST_RS_CHK,
    ST_WALK_START,
    ST_WALK,
    ST_APPEND,
    ST_DONE
  } state_t;

  // finished result handed from the engine to the output register
  typedef struct packed {
    logic                valid;
    logic [OFFSET_W-1:0] payload_offset;
    status_t             status;
  } res_t;

endpackage

`default_nettype wire

[design/ffa_if.sv]
// request and response channel interfaces of the allocator
`default_nettype none

interface ffa_req_if;
  logic                         valid;
  logic                         ready;
  logic [ffa_pkg::OPCODE_W-1:0] opcode;
  logic [ffa_pkg::BYTES_W-1:0]  request_bytes;
  logic [ffa_pkg::OFFSET_W-1:0] block_offset;

  modport source (output valid, opcode, request_bytes, block_offset, input ready);
  modport sink (input valid, opcode, request_bytes, block_offset, output ready);
endinterface

interface ffa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffa_pkg::OFFSET_W-1:0] payload_offset;
  logic [ffa_pkg::STATUS_W-1:0] status;

  modport source (output valid, payload_offset, status, input ready);
  modport sink (input valid, payload_offset, status, output ready);
endinterface

`default_nettype wire

[design/ffa_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/ffa_engine.sv]
// sequencer that walks, reads and rewrites the header store
`default_nettype none

module ffa_engine #(
  parameter int HEAP_GRANULES = ffa_pkg::HEAP_GRANULES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  ffa_req_if.sink            req,
  output ffa_pkg::res_t      res,
  input  wire logic          res_ack
);

  import ffa_pkg::*;

  localparam int AW = $clog2(HEAP_GRANULES);

  state_t state_q, state_next;

  logic [PTR_W-1:0]    end_q, end_next;
  logic [PTR_W-1:0]    ptr_q, ptr_next;
  logic [NEED_W-1:0]   need_q, need_next;
  logic [BYTES_W-1:0]  bytes_q, bytes_next;
  logic [AW-1:0]       hdr_q, hdr_next;
  logic                post_free_q, post_free_next;
  logic [OFFSET_W-1:0] res_off_q, res_off_next;
  status_t             res_st_q, res_st_next;

  // header store port signals
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  ffa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_GRANULES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // decode of the incoming transaction
  logic [NEED_W-1:0]  need_in;
  logic [FIELD_W-1:0] h_in;
  logic               loc_ok;
  logic               bytes_zero;
  logic               off_zero;

  assign need_in    = NEED_W'((BYTES_W + 1)'(req.request_bytes) + (BYTES_W + 1)'(15)
                              >> GRAN_LOG2);
  assign h_in       = req.block_offset[OFFSET_W-1:GRAN_LOG2] - FIELD_W'(1);
  assign bytes_zero = (req.request_bytes == '0);
  assign off_zero   = (req.block_offset == '0);
  assign loc_ok     = !off_zero && (req.block_offset[GRAN_LOG2-1:0] == '0)
                      && ({1'b0, h_in} < end_q);

  // fields of the header just read
  logic               e_free;
  logic [FIELD_W-1:0] e_size;
  logic [FIELD_W-1:0] e_span;
  logic               fit;
  logic [PTR_W-1:0]   walk_nxt;
  logic               walk_more;
  logic [BYTES_W-1:0] cur_bytes;
  logic               oom;
  logic [PTR_W-1:0]   ptr_inc;
  logic [PTR_W-1:0]   end_inc;

  assign e_free    = mem_rdata[FREE_B];
  assign e_size    = mem_rdata[FREE_B-1:FIELD_W];
  assign e_span    = mem_rdata[FIELD_W-1:0];
  assign fit       = e_free && (need_q <= NEED_W'(e_size));
  assign walk_nxt  = ptr_q + PTR_W'(1) + PTR_W'(e_span);
  assign walk_more = (walk_nxt < end_q);
  assign cur_bytes = {e_size, {GRAN_LOG2{1'b0}}};
  assign oom       = ((PTR_W + 1)'(end_q) + (PTR_W + 1)'(1) + (PTR_W + 1)'(need_q))
                     > (PTR_W + 1)'(HEAP_GRANULES);
  assign ptr_inc   = ptr_q + PTR_W'(1);
  assign end_inc   = end_q + PTR_W'(1);

  assign req.ready = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_next = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          case (opcode_t'(req.opcode))
            OP_ALLOC:  state_next = bytes_zero ? ST_DONE : ST_WALK_START;
            OP_FREE:   state_next = loc_ok ? ST_FREE_RD : ST_DONE;
            OP_RESIZE: begin
              if (bytes_zero) begin
                state_next = loc_ok ? ST_FREE_RD : ST_DONE;
              end else if (off_zero) begin
                state_next = ST_WALK_START;
              end else begin
                state_next = loc_ok ? ST_RS_RD : ST_DONE;
              end
            end
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_FREE_RD:    state_next = ST_FREE_WR;
      ST_FREE_WR:    state_next = ST_DONE;
      ST_RS_RD:      state_next = ST_RS_CHK;
      ST_RS_CHK: begin
        if (cur_bytes == '0 || bytes_q == cur_bytes) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_WALK_START;
        end
      end
      ST_WALK_START: state_next = (end_q != '0) ? ST_WALK : ST_APPEND;
      ST_WALK: begin
        if (fit) begin
          state_next = post_free_q ? ST_FREE_RD : ST_DONE;
        end else if (!walk_more) begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (!oom && post_free_q) begin
          state_next = ST_FREE_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE:       state_next = res_ack ? ST_IDLE : ST_DONE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // datapath and memory accesses
  always_comb begin
    end_next       = end_q;
    ptr_next       = ptr_q;
    need_next      = need_q;
    bytes_next     = bytes_q;
    hdr_next       = hdr_q;
    post_free_next = post_free_q;
    res_off_next   = res_off_q;
    res_st_next    = res_st_q;
    mem_we         = 1'b0;
    mem_waddr      = hdr_q;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = hdr_q;
    case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          need_next      = need_in;
          bytes_next     = req.request_bytes;
          hdr_next       = h_in[AW-1:0];
          post_free_next = 1'b0;
          res_st_next    = STATUS_OK;
          res_off_next   = '0;
          case (opcode_t'(req.opcode))
            OP_ALLOC: begin
              if (bytes_zero) begin
                res_st_next = STATUS_NULL;
              end
            end
            OP_RESIZE: begin
              if (bytes_zero || !off_zero) begin
                res_off_next = req.block_offset;
              end
            end
            default: begin
              res_off_next = '0;
            end
          endcase
        end
      end
      ST_FREE_RD, ST_RS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = hdr_q;
      end
      ST_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hdr_q;
        mem_wdata = mem_rdata | (ENTRY_W'(1) << FREE_B);
      end
      ST_RS_CHK: begin
        // smaller: free first, larger: free only after a successful allocate
        if (cur_bytes != '0 && bytes_q != cur_bytes) begin
          if (bytes_q < cur_bytes) begin
            mem_we    = 1'b1;
            mem_waddr = hdr_q;
            mem_wdata = mem_rdata | (ENTRY_W'(1) << FREE_B);
          end else begin
            post_free_next = 1'b1;
          end
        end
      end
      ST_WALK_START: begin
        ptr_next  = '0;
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      ST_WALK: begin
        if (fit) begin
          // reuse: new size, old span
          mem_we       = 1'b1;
          mem_waddr    = ptr_q[AW-1:0];
          mem_wdata    = {1'b0, need_q[FIELD_W-1:0], e_span};
          res_off_next = {ptr_inc[FIELD_W-1:0], {GRAN_LOG2{1'b0}}};
          res_st_next  = STATUS_OK;
        end else begin
          ptr_next = walk_nxt;
          if (walk_more) begin
            mem_re    = 1'b1;
            mem_raddr = walk_nxt[AW-1:0];
          end
        end
      end
      ST_APPEND: begin
        if (oom) begin
          res_off_next = '0;
          res_st_next  = STATUS_OOM;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = end_q[AW-1:0];
          mem_wdata    = {1'b0, need_q[FIELD_W-1:0], need_q[FIELD_W-1:0]};
          res_off_next = {end_inc[FIELD_W-1:0], {GRAN_LOG2{1'b0}}};
          res_st_next  = STATUS_OK;
          end_next     = end_q + PTR_W'(1) + PTR_W'(need_q);
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q     <= ST_IDLE;
      end_q       <= '0;
      post_free_q <= 1'b0;
    end else begin
      state_q     <= state_next;
      end_q       <= end_next;
      post_free_q <= post_free_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ptr_q     <= ptr_next;
    need_q    <= need_next;
    bytes_q   <= bytes_next;
    hdr_q     <= hdr_next;
    res_off_q <= res_off_next;
    res_st_q  <= res_st_next;
  end

  assign res.valid          = (state_q == ST_DONE);
  assign res.payload_offset = res_off_q;
  assign res.status         = res_st_q;

endmodule

`default_nettype wire

[design/first_fit_block_allocator.sv]
// top level: first-fit allocator engine with response output register
// a free reads the header and rewrites it with the free bit set; an allocate walks the
// headers from the start and reuses the first free fit, or appends at the heap end
// one transaction in flight: the next is accepted in the cycle after its result
// is loaded into the output register
// reset clears the heap end pointer and control; header ram is not cleared (no sweep)
`default_nettype none

module first_fit_block_allocator #(
  parameter int HEAP_GRANULES = ffa_pkg::HEAP_GRANULES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ffa_req_if.sink   req,
  ffa_rsp_if.source rsp
);

  import ffa_pkg::*;

  res_t res;
  logic res_ack;

  logic                rsp_valid_q, rsp_valid_next;
  logic [OFFSET_W-1:0] rsp_off_q;
  logic [STATUS_W-1:0] rsp_st_q;

  ffa_engine #(
    .HEAP_GRANULES (HEAP_GRANULES)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res     (res),
    .res_ack (res_ack)
  );

  // load the output register when empty or being drained
  assign res_ack = res.valid && (!rsp_valid_q || rsp.ready);

  always_comb begin
    rsp_valid_next = rsp_valid_q;
    if (res_ack) begin
      rsp_valid_next = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      rsp_off_q <= res.payload_offset;
      rsp_st_q  <= res.status;
    end
  end

  assign rsp.valid          = rsp_valid_q;
  assign rsp.payload_offset = rsp_off_q;
  assign rsp.status         = rsp_st_q;

endmodule

`default_nettype wire

[dv/allocator_checker.sv]
// checker for the first-fit allocator: predicts every result and compares it
`timescale 1ns / 100ps

module allocator_checker #(
  parameter int HEAP_GRANULES = ffa_pkg::HEAP_GRANULES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ffa_req_if          req,
  ffa_rsp_if          rsp,
  output int unsigned failures,
  output int unsigned waiting
);
  import ffa_pkg::*;

  localparam int GRAN_BYTES = 1 << GRAN_LOG2;
  localparam int SHOW_LIMIT = 10;

  // one header granule: free flag, recorded size, owned span
  typedef struct packed {
    logic               free;
    logic [FIELD_W-1:0] rec;
    logic [FIELD_W-1:0] span;
  } hdr_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] off;
    status_t             st;
  } outcome_t;

  hdr_t        hdr_mem [HEAP_GRANULES];
  int unsigned heap_end;
  outcome_t    due_results [$];

  outcome_t            want;
  logic [OFFSET_W-1:0] res_off;
  status_t             res_st;

  // entries never written read as zero here, the walk never reaches them anyway
  initial begin
    for (int i = 0; i < HEAP_GRANULES; i++) hdr_mem[i] = '0;
  end

  // first-fit walk, append at the heap end when nothing fits
  function automatic void claim_block(input logic [BYTES_W-1:0] nbytes,
                                      output logic [OFFSET_W-1:0] off, output status_t st);
    int unsigned need;
    int unsigned g;
    hdr_t h;
    off = '0;
    st = STATUS_OK;
    if (nbytes == '0) begin
      st = STATUS_NULL;
      return;
    end
    need = (nbytes + GRAN_BYTES - 1) / GRAN_BYTES;
    g = 0;
    while (g < heap_end && g < HEAP_GRANULES) begin
      h = hdr_mem[g];
      if (h.free && need <= h.rec) begin
        // reused block keeps its span, records the new size
        h.free = 1'b0;
        h.rec = FIELD_W'(need);
        hdr_mem[g] = h;
        off = OFFSET_W'((g + 1) * GRAN_BYTES);
        return;
      end
      g += 1 + h.span;
    end
    if (heap_end + 1 + need > HEAP_GRANULES) begin
      st = STATUS_OOM;
      return;
    end
    hdr_mem[heap_end] = '{free: 1'b0, rec: FIELD_W'(need), span: FIELD_W'(need)};
    off = OFFSET_W'((heap_end + 1) * GRAN_BYTES);
    heap_end += 1 + need;
  endfunction

  // header granule of a payload offset, if it names one below the heap end
  function automatic bit header_of(input logic [OFFSET_W-1:0] off, output int unsigned g);
    g = 0;
    if (off == '0 || off[GRAN_LOG2-1:0] != '0) return 1'b0;
    g = (off >> GRAN_LOG2) - 1;
    return g < heap_end && g < HEAP_GRANULES;
  endfunction

  function automatic void release_block(input logic [OFFSET_W-1:0] off);
    int unsigned g;
    if (header_of(off, g)) hdr_mem[g].free = 1'b1;
  endfunction

  // resize: shrink frees first, growth allocates first and keeps the old block on failure
  function automatic void regrow_block(input logic [BYTES_W-1:0] nbytes,
                                       input logic [OFFSET_W-1:0] off,
                                       output logic [OFFSET_W-1:0] res, output status_t st);
    int unsigned g;
    int unsigned cur;
    if (nbytes == '0) begin
      release_block(off);
      res = off;
      st = STATUS_OK;
      return;
    end
    if (off == '0) begin
      claim_block(nbytes, res, st);
      return;
    end
    res = off;
    st = STATUS_OK;
    if (!header_of(off, g)) return;
    cur = GRAN_BYTES * hdr_mem[g].rec;
    if (cur == 0 || nbytes == cur) return;
    if (nbytes < cur) begin
      release_block(off);
      claim_block(nbytes, res, st);
      return;
    end
    claim_block(nbytes, res, st);
    if (st == STATUS_OK) release_block(off);
  endfunction

  // compare finished results, then predict for the accepted request
  always @(posedge clk) begin
    if (rst) begin
      heap_end = 0;
      due_results.delete();
      failures = 0;
      waiting = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          failures++;
          if (failures <= SHOW_LIMIT)
            $display("%0t: result with nothing expected: offset %h status %0d",
                     $realtime, rsp.payload_offset, rsp.status);
        end else begin
          want = due_results.pop_front();
          if (rsp.payload_offset !== want.off || rsp.status !== want.st) begin
            failures++;
            if (failures <= SHOW_LIMIT)
              $display("%0t: mismatch: expected offset %h status %0d, got offset %h status %0d",
                       $realtime, want.off, want.st, rsp.payload_offset, rsp.status);
          end
        end
      end
      if (req.valid && req.ready) begin
        res_off = '0;
        res_st = STATUS_OK;
        case (req.opcode)
          OP_ALLOC: begin
            claim_block(req.request_bytes, res_off, res_st);
          end
          OP_FREE: begin
            release_block(req.block_offset);
          end
          OP_RESIZE: begin
            regrow_block(req.request_bytes, req.block_offset, res_off, res_st);
          end
          default: begin
            // unused opcode: no change, zero offset with status ok
          end
        endcase
        due_results.push_back('{off: res_off, st: res_st});
      end
      waiting = due_results.size();
    end
  end

endmodule

[dv/tb_first_fit_block_allocator.sv]
// testbench top for the first-fit allocator: stimulus, handshake idling and verdict
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;
  import ffa_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;
  localparam int NGRAN      = HEAP_GRANULES_DEF;
  localparam int LAST_GRAN  = NGRAN - 2;
  localparam int DRAIN_CYC  = 2100;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [BYTES_W-1:0]  nbytes;
    logic [OFFSET_W-1:0] off;
  } req_note_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;

  ffa_req_if req_ch ();
  ffa_rsp_if rsp_ch ();

  int unsigned chk_failures;
  int unsigned chk_waiting;

  // requests in flight, block offsets seen so far and their recorded sizes
  req_note_t           issued_reqs [$];
  logic [OFFSET_W-1:0] block_offs [$];
  bit                  known_hdr [NGRAN];
  int unsigned         rec_gran [NGRAN];
  int unsigned         end_bound = 0;

  req_note_t   done_req;
  int unsigned done_g;

  first_fit_block_allocator uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  allocator_checker chk (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .failures (chk_failures),
    .waiting  (chk_waiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // response side stalls about one cycle in ten outside the calm stretch
  always @(posedge clk) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
  end

  // learn block offsets from completed allocations, for later free and resize
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && issued_reqs.size() != 0) begin
      done_req = issued_reqs.pop_front();
      if (rsp_ch.status == STATUS_OK && rsp_ch.payload_offset != '0 &&
          rsp_ch.payload_offset[GRAN_LOG2-1:0] == '0 && done_req.nbytes != '0) begin
        done_g = (rsp_ch.payload_offset >> GRAN_LOG2) - 1;
        if (done_req.op == OP_ALLOC ||
            (done_req.op == OP_RESIZE &&
             (rsp_ch.payload_offset != done_req.off || known_hdr[done_g]))) begin
          if (!known_hdr[done_g]) begin
            known_hdr[done_g] = 1'b1;
            block_offs.push_back(rsp_ch.payload_offset);
          end
          rec_gran[done_g] = (done_req.nbytes + 15) / 16;
        end
      end
    end
  end

  // one transaction, with an occasional idle gap before it
  task automatic send_req(input logic [OPCODE_W-1:0] op, input logic [BYTES_W-1:0] nbytes,
                          input logic [OFFSET_W-1:0] off);
    int unsigned need;
    if (!calm && $urandom_range(99) < 10) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.request_bytes <= nbytes;
    req_ch.block_offset <= off;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    issued_reqs.push_back('{op: op, nbytes: nbytes, off: off});
    // upper bound on the heap end, so offsets above it are surely past the end
    if ((op == OP_ALLOC || op == OP_RESIZE) && nbytes != '0) begin
      need = (nbytes + 15) / 16;
      end_bound = (end_bound + 1 + need > NGRAN) ? NGRAN : end_bound + 1 + need;
    end
  endtask

  // hold off the sender until every result is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (issued_reqs.size() != 0) @(posedge clk);
  endtask

  // mostly small requests, a few large ones that mostly run out of heap
  function automatic logic [BYTES_W-1:0] pick_bytes();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 80) return BYTES_W'($urandom_range(256, 1));
    if (r < 97) return BYTES_W'($urandom_range(2048, 257));
    if (r < 98) return BYTES_W'($urandom_range(16384, 2049));
    return BYTES_W'($urandom_range(65535, 16385));
  endfunction

  function automatic logic [OFFSET_W-1:0] skewed_offset();
    logic [OFFSET_W-1:0] off;
    off = OFFSET_W'($urandom);
    if (off[GRAN_LOG2-1:0] == '0) off[0] = 1'b1;
    return off;
  endfunction

  task automatic random_item();
    logic [OPCODE_W-1:0] op;
    logic [BYTES_W-1:0]  nbytes;
    logic [OFFSET_W-1:0] off;
    int unsigned r;
    int unsigned g;
    int unsigned cur;
    r = $urandom_range(99);
    nbytes = pick_bytes();
    off = '0;
    op = OP_ALLOC;
    if (r >= 93) begin
      // noise: unused opcode, bad offsets, null offsets
      case ($urandom_range(5))
        0: begin
          op = OP_NOP;
          nbytes = BYTES_W'($urandom);
          off = OFFSET_W'($urandom);
        end
        1: begin
          op = OP_FREE;
          off = skewed_offset();
        end
        2: begin
          op = OP_RESIZE;
          off = skewed_offset();
        end
        3: begin
          op = ($urandom_range(1) == 0) ? OP_FREE : OP_RESIZE;
          if (end_bound <= LAST_GRAN)
            off = OFFSET_W'(($urandom_range(LAST_GRAN, end_bound) + 1) * 16);
        end
        4: op = OP_FREE;
        default: op = OP_RESIZE;
      endcase
    end else if (r >= 40 && block_offs.size() != 0) begin
      off = block_offs[$urandom_range(block_offs.size() - 1)];
      if (r < 65) begin
        op = OP_FREE;
      end else begin
        op = OP_RESIZE;
        g = (off >> GRAN_LOG2) - 1;
        cur = rec_gran[g] * 16;
        case ($urandom_range(3))
          0: nbytes = BYTES_W'(cur);
          1: nbytes = BYTES_W'($urandom_range(cur, 1));
          default: begin
          end
        endcase
      end
    end
    send_req(op, nbytes, off);
  endtask

  initial begin
    int n;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_ALLOC;
    req_ch.request_bytes <= '0;
    req_ch.block_offset <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty heap, null and bad offsets, size extremes, reuse and resize paths
    send_req(OP_FREE, 16'd0, 16'h0010);
    send_req(OP_RESIZE, 16'd100, 16'hfff0);
    send_req(OP_ALLOC, 16'd0, 16'd0);
    send_req(OP_ALLOC, 16'd1, 16'd0);
    send_req(OP_ALLOC, 16'd16, 16'd0);
    send_req(OP_ALLOC, 16'd17, 16'd0);
    send_req(OP_FREE, 16'd0, 16'd0);
    send_req(OP_FREE, 16'd0, 16'h0015);
    send_req(OP_RESIZE, 16'd0, 16'hffff);
    send_req(OP_RESIZE, 16'hffff, 16'd0);
    send_req(OP_ALLOC, 16'hfff0, 16'd0);
    send_req(OP_FREE, 16'd0, 16'd16);
    send_req(OP_ALLOC, 16'd10, 16'd0);
    send_req(OP_RESIZE, 16'd32, 16'd80);
    send_req(OP_RESIZE, 16'd20, 16'd80);
    send_req(OP_RESIZE, 16'd40, 16'd48);
    send_req(OP_ALLOC, 16'd5, 16'd0);
    send_req(OP_RESIZE, 16'd0, 16'd128);
    send_req(OP_ALLOC, 16'd33, 16'd0);
    send_req(OP_RESIZE, 16'hffff, 16'd16);
    send_req(OP_FREE, 16'd0, 16'd48);
    send_req(OP_RESIZE, 16'd8, 16'd48);
    send_req(OP_NOP, 16'h5a5a, 16'ha5a5);
    send_req(OP_ALLOC, 16'd48, 16'd0);
    send_req(OP_RESIZE, 16'd47, 16'd192);
    wait_drained();

    // random traffic, with a stretch where neither side idles
    for (n = 0; n < 600; n++) random_item();
    wait_drained();
    calm <= 1'b1;
    for (n = 0; n < 400; n++) random_item();
    calm <= 1'b0;
    for (n = 0; n < 625; n++) random_item();
    wait_drained();

    // let any stray result show up before the verdict
    repeat (DRAIN_CYC) @(posedge clk);
    if (chk_failures == 0 && chk_waiting == 0)
      $display("tb_first_fit_block_allocator: done, clean");
    else
      $display("tb_first_fit_block_allocator: done, errors");
    $finish;
  end

  // run guard against a hung handshake
  initial begin
    #60_000_000;
    $display("tb_first_fit_block_allocator: done, errors");
    $finish;
  end

endmodule
